/* src/pech_pkg.sv */
// shared types, codes and defaults for the pwm encoder capture history block
package pech_pkg;

	localparam int PECH_HISTORY_DEPTH = 8;
	localparam int PECH_COUNTER_WIDTH = 16;
	localparam int WORD_W = 16;

	// item kinds on the input stream
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_RISE = 2'd1;
	localparam logic [1:0] OP_FALL = 2'd2;
	localparam logic [1:0] OP_CMD  = 2'd3;

	// edge source
	localparam logic JOINT_UPPER = 1'b0;
	localparam logic JOINT_LOWER = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_SUMMED_SAMPLES   = 2'd0;
	localparam logic [1:0] CFG_GROUP_LENGTH     = 2'd1;
	localparam logic [1:0] CFG_CALIBRATION_CODE = 2'd2;

	localparam logic [4:0] SUMMED_SAMPLES_RST   = 5'd4;
	localparam logic [4:0] GROUP_LENGTH_RST     = 5'd8;
	localparam logic [7:0] CALIBRATION_CODE_RST = 8'd127;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOWER,
		ST_UPPER
	} pech_state_t;

	// controller to datapath
	typedef struct packed {
		logic accept; // input transfer this edge
		logic start;  // command transfer, readback begins
		logic issue;  // read one history word into the output stage
		logic upper;  // word comes from the upper joint
		logic last;   // final word of the run
	} pech_cmd_t;

	typedef struct packed {
		logic       enable;
		logic       reverse;
		logic       forward;
		logic [7:0] duty;
	} motor_t;

endpackage

/* src/pech_ctrl.sv */
// readback sequencer and output valid control
module pech_ctrl import pech_pkg::*; #(
	parameter int HISTORY_DEPTH = PECH_HISTORY_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic [1:0] op,
	output logic       s_tready,
	input  logic       m_tready,
	output logic       m_tvalid,
	output pech_cmd_t  cmd
);

	localparam int SW = $clog2(HISTORY_DEPTH);
	localparam logic [SW-1:0] IDX_LAST = SW'(HISTORY_DEPTH - 1);

	pech_state_t state_q, state_d;
	logic [SW-1:0] idx_q;
	logic out_valid_q;
	logic at_end;

	assign at_end = (idx_q == IDX_LAST);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.start) state_d = ST_LOWER;
			end
			ST_LOWER: begin
				if (cmd.issue && at_end) state_d = ST_UPPER;
			end
			ST_UPPER: begin
				if (cmd.issue && at_end) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready  = 1'b0;
		cmd.issue = 1'b0;
		cmd.upper = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_LOWER: begin
				cmd.issue = !out_valid_q || m_tready;
			end
			ST_UPPER: begin
				cmd.issue = !out_valid_q || m_tready;
				cmd.upper = 1'b1;
			end
			default: s_tready = 1'b0;
		endcase
		cmd.accept = s_tvalid && s_tready;
		cmd.start  = cmd.accept && (op == OP_CMD);
		cmd.last   = cmd.upper && at_end;
	end

	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.start) idx_q <= '0;
			else if (cmd.issue) idx_q <= at_end ? '0 : idx_q + 1'b1;
			if (cmd.issue) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	a_issue_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (!out_valid_q || m_tready))
		else $error("word issued over a pending output");

	a_start_lower: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == ST_LOWER && idx_q == '0))
		else $error("readback did not start at the first lower word");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && cmd.last) |=> (state_q == ST_IDLE && out_valid_q))
		else $error("run did not end after the last word");

endmodule

/* src/pech_joint.sv */
// one joint: counter, high-time sum, group position, ring slot and two histories
module pech_joint import pech_pkg::*; #(
	parameter int HISTORY_DEPTH = PECH_HISTORY_DEPTH,
	parameter int COUNTER_WIDTH = PECH_COUNTER_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick,
	input  logic              rise,
	input  logic              fall,
	input  logic [4:0]        summed_samples,
	input  logic [4:0]        group_length,
	input  logic              start,
	input  logic              rd_en,
	input  logic              sel_period,
	output logic [WORD_W-1:0] word
);

	localparam int SW = $clog2(HISTORY_DEPTH);
	localparam int XW = (COUNTER_WIDTH > WORD_W) ? COUNTER_WIDTH : WORD_W;
	localparam logic [SW-1:0] SLOT_LAST = SW'(HISTORY_DEPTH - 1);

	logic [COUNTER_WIDTH-1:0] counter_q, sum_q, sum_new;
	logic [3:0]               gp_q;
	logic [SW-1:0]            slot_q, rp_q;
	logic [4:0]               gp_inc;
	logic                     store_sum;
	logic [3:0]               gp_next;

	logic [COUNTER_WIDTH-1:0] high_mem [HISTORY_DEPTH];
	logic [COUNTER_WIDTH-1:0] period_mem [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] high_vld_q, period_vld_q;

	logic [COUNTER_WIDTH-1:0] high_rd_s1, period_rd_s1;
	logic                     high_vld_s1, period_vld_s1, sel_s1;
	logic [XW-1:0]            pick;

	always_comb begin
		sum_new = sum_q;
		if ({1'b0, gp_q} < summed_samples) sum_new = sum_q + counter_q;
		gp_inc    = {1'b0, gp_q} + 5'd1;
		store_sum = (gp_inc == summed_samples);
		gp_next   = gp_inc[3:0];
		if ({1'b0, gp_next} >= group_length) gp_next = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q    <= '0;
			sum_q        <= '0;
			gp_q         <= '0;
			slot_q       <= '0;
			rp_q         <= '0;
			high_vld_q   <= '0;
			period_vld_q <= '0;
		end else begin
			if (tick) counter_q <= counter_q + 1'b1;
			if (rise) begin
				counter_q            <= '0;
				period_vld_q[slot_q] <= 1'b1;
			end
			if (fall) begin
				gp_q <= gp_next;
				if (store_sum) begin
					sum_q              <= '0;
					high_vld_q[slot_q] <= 1'b1;
					slot_q             <= (slot_q == SLOT_LAST) ? '0 : slot_q + 1'b1;
				end else begin
					sum_q <= sum_new;
				end
			end
			if (start) rp_q <= slot_q;
			else if (rd_en) rp_q <= (rp_q == SLOT_LAST) ? '0 : rp_q + 1'b1;
		end
	end

	// history memories, written on edges and read one word per issue
	always_ff @(posedge clk) begin
		if (rise) period_mem[slot_q] <= counter_q;
		if (fall && store_sum) high_mem[slot_q] <= sum_new;
		if (rd_en) begin
			high_rd_s1    <= high_mem[rp_q];
			period_rd_s1  <= period_mem[rp_q];
			high_vld_s1   <= high_vld_q[rp_q];
			period_vld_s1 <= period_vld_q[rp_q];
			sel_s1        <= sel_period;
		end
	end

	always_comb begin
		pick = '0;
		if (sel_s1) begin
			if (period_vld_s1) pick = XW'(period_rd_s1);
		end else begin
			if (high_vld_s1) pick = XW'(high_rd_s1);
		end
		word = pick[WORD_W-1:0];
	end

endmodule

/* src/pech_datapath.sv */
// configuration, motor decode, both joints and the output stage
module pech_datapath import pech_pkg::*; #(
	parameter int HISTORY_DEPTH = PECH_HISTORY_DEPTH,
	parameter int COUNTER_WIDTH = PECH_COUNTER_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pech_cmd_t         cmd,
	input  logic [1:0]        op,
	input  logic              joint,
	input  logic [7:0]        command_byte,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [7:0]        cfg_data,
	output logic [WORD_W-1:0] data_word,
	output logic              last,
	output motor_t            motor
);

	logic [4:0] summed_samples_q, group_length_q;
	logic [7:0] calibration_code_q;
	logic       calib_q, is_calib;
	motor_t     motor_q, motor_s1, motor_d;
	logic       upper_s1, last_s1;
	logic       tick, rise, fall;
	logic [WORD_W-1:0] upper_word, lower_word;

	assign tick     = cmd.accept && (op == OP_TICK);
	assign rise     = cmd.accept && (op == OP_RISE);
	assign fall     = cmd.accept && (op == OP_FALL);
	assign is_calib = (command_byte == calibration_code_q);

	always_comb begin
		motor_d = '0;
		if (command_byte != 8'd0 && !is_calib) begin
			motor_d.enable  = 1'b1;
			motor_d.reverse = command_byte[7];
			motor_d.forward = ~command_byte[7];
			motor_d.duty    = {command_byte[6:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			summed_samples_q   <= SUMMED_SAMPLES_RST;
			group_length_q     <= GROUP_LENGTH_RST;
			calibration_code_q <= CALIBRATION_CODE_RST;
			motor_q            <= '0;
			calib_q            <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_SUMMED_SAMPLES:   summed_samples_q   <= cfg_data[4:0];
					CFG_GROUP_LENGTH:     group_length_q     <= cfg_data[4:0];
					CFG_CALIBRATION_CODE: calibration_code_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.start) begin
				motor_q <= motor_d;
				calib_q <= is_calib;
			end
		end
	end

	// output stage payload, loaded with each issued word
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			motor_s1 <= motor_q;
			upper_s1 <= cmd.upper;
			last_s1  <= cmd.last;
		end
	end

	pech_joint #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_upper (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick          (tick),
		.rise          (rise && joint == JOINT_UPPER),
		.fall          (fall && joint == JOINT_UPPER),
		.summed_samples(summed_samples_q),
		.group_length  (group_length_q),
		.start         (cmd.start),
		.rd_en         (cmd.issue && cmd.upper),
		.sel_period    (calib_q),
		.word          (upper_word)
	);

	pech_joint #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_lower (
		.clk           (clk),
		.arst_n        (arst_n),
		.tick          (tick),
		.rise          (rise && joint == JOINT_LOWER),
		.fall          (fall && joint == JOINT_LOWER),
		.summed_samples(summed_samples_q),
		.group_length  (group_length_q),
		.start         (cmd.start),
		.rd_en         (cmd.issue && !cmd.upper),
		.sel_period    (calib_q),
		.word          (lower_word)
	);

	assign data_word = upper_s1 ? upper_word : lower_word;
	assign last      = last_s1;
	assign motor     = motor_s1;

endmodule

/* src/pwm_encoder_capture_history.sv */
// top level of the pwm encoder capture history block
//
// Two-joint PWM input capture with a ring of recent measurements per joint.
// Tick, rising-edge and falling-edge items produce no output: a tick advances
// both free-running counters, a rising edge stores the joint's counter as its
// period in the current ring slot and clears the counter, and a falling edge
// adds the counter to the high-time sum during the first summed_samples edges
// of each group, storing the sum and advancing the slot on the last summed
// edge. A command item sets the motor drive (zero or the calibration code
// means all stop) and starts a readback of 2 x HISTORY_DEPTH words, lower
// joint oldest first, then upper joint; periods are read on the calibration
// code, sums otherwise. The readback sequencer reads one history word per
// cycle from the ring memories while the output is not stalled, and no input
// is taken until the last word has been issued into the output register.
// Entries never written read back as zero through per-entry valid bits; no
// clearing pass is needed after reset. Configuration writes are taken every
// cycle.
module pwm_encoder_capture_history import pech_pkg::*; #(
	parameter int HISTORY_DEPTH = PECH_HISTORY_DEPTH,
	parameter int COUNTER_WIDTH = PECH_COUNTER_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] command_byte
	input  logic [2:0]  s_tuser,   // [1:0] op, [2] joint
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] data_word, [16] motor_enable,
	                               // [17] reverse_drive, [18] forward_drive,
	                               // [26:19] duty, [31:27] zero
	output logic        m_tlast,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	pech_cmd_t         cmd;
	logic [WORD_W-1:0] data_word;
	motor_t            motor;

	// configuration is always taken
	assign cfg_ready = 1'b1;

	pech_ctrl #(
		.HISTORY_DEPTH(HISTORY_DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.op      (s_tuser[1:0]),
		.s_tready(s_tready),
		.m_tready(m_tready),
		.m_tvalid(m_tvalid),
		.cmd     (cmd)
	);

	pech_datapath #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.COUNTER_WIDTH(COUNTER_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.op          (s_tuser[1:0]),
		.joint       (s_tuser[2]),
		.command_byte(s_tdata),
		.cfg_write   (cfg_valid && cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.data_word   (data_word),
		.last        (m_tlast),
		.motor       (motor)
	);

	// pack the result fields, highest first
	assign m_tdata = {5'd0, motor.duty, motor.forward, motor.reverse, motor.enable, data_word};

endmodule

/* test/tb_pwm_encoder_capture_history.sv */
// testbench for the pwm encoder capture history block with a predictor
`timescale 1ns / 1ps

module tb_pwm_encoder_capture_history;
	import pech_pkg::*;

	localparam int DEPTH       = PECH_HISTORY_DEPTH;
	localparam int QUIET_LIMIT = 2000;  // cycles with no transfer at all
	localparam int HOLD_CYCLES = 300;   // long receiver hold-off
	localparam int SETTLE      = 4;     // cycles after the last word, tick in flight

	typedef struct packed {
		logic [1:0] op;
		logic       joint;
		logic [7:0] cmd;
	} pwm_item_t;

	typedef struct packed {
		logic [15:0] word;
		logic        last;
		motor_t      motor;
	} readback_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // [7:0] command_byte
	logic [2:0]  s_tuser = '0;   // [1:0] op, [2] joint
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;       // [15:0] data_word, [16] motor_enable, [17] reverse_drive,
	                            // [18] forward_drive, [26:19] duty
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	pwm_encoder_capture_history dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// ---------------------------------------------------------------- predictor state
	// index 0 is the upper joint, index 1 the lower joint
	logic [15:0] edge_count [2];
	logic [15:0] high_sum [2];
	logic [3:0]  group_pos [2];
	int          ring_slot [2];
	logic [15:0] high_ring [2][DEPTH];
	logic [15:0] period_ring [2][DEPTH];
	motor_t      drive;
	logic [4:0]  summed_cfg;
	logic [4:0]  group_cfg;
	logic [7:0]  calib_cfg;

	readback_word_t readback_words [$];  // words still owed by the block
	pwm_item_t      pending_items [$];   // items not yet offered
	pwm_item_t      tx_item;             // item on the input bus
	bit             in_taken = 1'b0;     // set at the edge that takes tx_item
	int             word_errors = 0;
	int             queued_events = 0;   // items queued, stops random fill

	// sender and receiver idling controls, owned by the sequencer
	bit tx_idle_on = 1'b0;
	bit rx_idle_on = 1'b0;
	bit hold_req = 1'b0;

	function automatic void clear_capture_model();
		for (int j = 0; j < 2; j++) begin
			edge_count[j] = '0;
			high_sum[j] = '0;
			group_pos[j] = '0;
			ring_slot[j] = 0;
			for (int i = 0; i < DEPTH; i++) begin
				high_ring[j][i] = '0;
				period_ring[j][i] = '0;
			end
		end
		drive = '0;
		summed_cfg = SUMMED_SAMPLES_RST;
		group_cfg = GROUP_LENGTH_RST;
		calib_cfg = CALIBRATION_CODE_RST;
	endfunction

	// advance the capture state by one item, queue the readback words of a command
	function automatic void advance_capture(pwm_item_t it);
		int          j;
		int          src;
		bit          calib;
		logic [3:0]  nxt;
		readback_word_t w;
		j = it.joint;
		case (it.op)
			OP_TICK: begin
				edge_count[0] = edge_count[0] + 16'd1;
				edge_count[1] = edge_count[1] + 16'd1;
			end
			OP_RISE: begin
				period_ring[j][ring_slot[j]] = edge_count[j];
				edge_count[j] = '0;
			end
			OP_FALL: begin
				if ({1'b0, group_pos[j]} < summed_cfg)
					high_sum[j] = high_sum[j] + edge_count[j];
				// last summed edge of the group closes the slot
				if ({1'b0, group_pos[j]} + 5'd1 == summed_cfg) begin
					high_ring[j][ring_slot[j]] = high_sum[j];
					high_sum[j] = '0;
					ring_slot[j] = (ring_slot[j] + 1) % DEPTH;
				end
				nxt = group_pos[j] + 4'd1;
				if ({1'b0, nxt} >= group_cfg)
					nxt = '0;
				group_pos[j] = nxt;
			end
			default: begin
				calib = (it.cmd == calib_cfg);
				// zero or the calibration code means all stop
				if (it.cmd != 8'd0 && !calib)
					drive = {1'b1, it.cmd[7], ~it.cmd[7], it.cmd[6:0], 1'b0};
				else
					drive = '0;
				// lower joint first, then upper, each oldest first
				for (int h = 0; h < 2; h++) begin
					src = (h == 0) ? int'(JOINT_LOWER) : int'(JOINT_UPPER);
					for (int i = 0; i < DEPTH; i++) begin
						w.word = calib ? period_ring[src][(ring_slot[src] + i) % DEPTH]
						               : high_ring[src][(ring_slot[src] + i) % DEPTH];
						w.last = (h == 1 && i == DEPTH - 1);
						w.motor = drive;
						readback_words.push_back(w);
					end
				end
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- stimulus helpers
	function automatic void push_item(logic [1:0] op, logic joint, logic [7:0] cmd_byte);
		pwm_item_t it;
		it.op = op;
		it.joint = joint;
		it.cmd = cmd_byte;
		pending_items.push_back(it);
		queued_events++;
	endfunction

	// ticks carry random don't-care joint and command fields
	function automatic void push_ticks(int n);
		for (int i = 0; i < n; i++)
			push_item(OP_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
	endfunction

	function automatic int tick_run();
		if ($urandom_range(0, 15) == 0)
			return $urandom_range(16, 40);
		return $urandom_range(0, 4);
	endfunction

	// bias toward stop codes and sign extremes
	function automatic logic [7:0] pick_command();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return calib_cfg;
			2: return 8'h80;
			3: return 8'hFF;
			4: return 8'h7F;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// mostly whole pulses (rise, high time, fall, low time), some commands and noise
	task automatic add_random_items(int count);
		int   target;
		int   r;
		logic j;
		target = queued_events + count;
		while (queued_events < target) begin
			r = $urandom_range(0, 99);
			j = 1'($urandom_range(0, 1));
			if (r < 70) begin
				push_item(OP_RISE, j, 8'($urandom_range(0, 255)));
				push_ticks(tick_run());
				push_item(OP_FALL, j, 8'($urandom_range(0, 255)));
				push_ticks(tick_run());
			end else if (r < 82) begin
				push_item(OP_CMD, j, pick_command());
			end else begin
				push_item(2'($urandom_range(0, 3)), j, 8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic write_reg(logic [1:0] idx, logic [7:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SUMMED_SAMPLES:   summed_cfg = value[4:0];
			CFG_GROUP_LENGTH:     group_cfg = value[4:0];
			CFG_CALIBRATION_CODE: calib_cfg = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(logic [7:0] summed, logic [7:0] group_len, logic [7:0] calib);
		write_reg(CFG_SUMMED_SAMPLES, summed);
		write_reg(CFG_GROUP_LENGTH, group_len);
		write_reg(CFG_CALIBRATION_CODE, calib);
	endtask

	// wait until every item is taken and every word has come back
	task automatic settle();
		do @(posedge clk);
		while (pending_items.size() != 0 || s_tvalid || readback_words.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// ---------------------------------------------------------------- input driver
	int tx_gap = 0;

	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			advance_capture(tx_item);
			in_taken = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			in_taken = 1'b0;
			if (tx_idle_on && tx_gap > 0) begin
				tx_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_items.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (tx_idle_on && $urandom_range(0, 7) == 0) begin
				// idle burst of random length, this cycle included
				tx_gap = $urandom_range(1, 16) - 1;
				s_tvalid <= 1'b0;
			end else begin
				tx_item = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= tx_item.cmd;
				s_tuser <= {tx_item.joint, tx_item.op};
			end
		end
	end

	// ---------------------------------------------------------------- receiver stalls
	int  rx_gap = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			// one long hold-off so the block backs up and stalls its input
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rx_idle_on && rx_gap > 0) begin
				rx_gap--;
				m_tready <= 1'b0;
			end else if (rx_idle_on && $urandom_range(0, 9) == 0) begin
				rx_gap = $urandom_range(1, 16) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- result checker
	readback_word_t got_word;
	readback_word_t want_word;

	function automatic string fmt_word(readback_word_t w);
		return $sformatf("word %h last %b en %b rev %b fwd %b duty %h", w.word, w.last,
		                 w.motor.enable, w.motor.reverse, w.motor.forward, w.motor.duty);
	endfunction

	task automatic report_mismatch(string want_s, string got_s);
		word_errors++;
		if (word_errors <= 10)
			$display("%0t mismatch: expected %s, got %s", $realtime, want_s, got_s);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_word = {m_tdata[15:0], m_tlast, m_tdata[16], m_tdata[17], m_tdata[18],
			            m_tdata[26:19]};
			if (readback_words.size() == 0) begin
				report_mismatch("no word", fmt_word(got_word));
			end else begin
				want_word = readback_words.pop_front();
				if (got_word.word !== want_word.word || got_word.last !== want_word.last ||
				    got_word.motor.enable !== want_word.motor.enable ||
				    got_word.motor.reverse !== want_word.motor.reverse ||
				    got_word.motor.forward !== want_word.motor.forward ||
				    got_word.motor.duty !== want_word.motor.duty)
					report_mismatch(fmt_word(want_word), fmt_word(got_word));
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
		    (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("** pwm_encoder_capture_history: FAILED **");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- sequencer
	initial begin
		clear_capture_model();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: readback of empty rings, stop codes, edges on both joints
		push_item(OP_CMD, JOINT_UPPER, 8'h00);
		push_item(OP_CMD, JOINT_LOWER, CALIBRATION_CODE_RST);
		push_ticks(3);
		push_item(OP_RISE, JOINT_UPPER, 8'hFF);
		push_item(OP_RISE, JOINT_LOWER, 8'h00);
		push_ticks(2);
		push_item(OP_FALL, JOINT_UPPER, 8'h00);
		push_item(OP_FALL, JOINT_LOWER, 8'hFF);
		push_ticks(1);
		push_item(OP_RISE, JOINT_LOWER, 8'h55);
		// lower joint reaches its fourth summed edge, slot advances
		push_item(OP_FALL, JOINT_LOWER, 8'hAA);
		push_item(OP_FALL, JOINT_LOWER, 8'h0F);
		push_item(OP_FALL, JOINT_LOWER, 8'hF0);
		push_item(OP_CMD, JOINT_UPPER, 8'h80);
		push_item(OP_CMD, JOINT_UPPER, 8'hFF);
		push_item(OP_CMD, JOINT_LOWER, 8'h01);
		push_item(OP_CMD, JOINT_UPPER, CALIBRATION_CODE_RST);
		push_item(OP_CMD, JOINT_LOWER, 8'h7E);
		settle();

		// shortest groups, calibration code zero collides with all stop
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		set_config(8'd1, 8'd1, 8'd0);
		add_random_items(25);
		settle();

		// widest groups, receiver holds off while commands pile up
		set_config(8'd16, 8'd16, 8'd255);
		hold_req = 1'b1;
		push_item(OP_CMD, JOINT_UPPER, 8'h33);
		push_item(OP_CMD, JOINT_LOWER, 8'hB3);
		add_random_items(30);
		settle();

		// no summing at all
		tx_idle_on = 1'b0;
		set_config(8'd0, 8'd5, 8'd200);
		add_random_items(25);
		settle();

		// summed count beyond the group, sums never stored
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b0;
		set_config(8'd10, 8'd4, 8'h80);
		add_random_items(25);
		settle();

		// group length zero acts as one
		rx_idle_on = 1'b1;
		set_config(8'd3, 8'd0, 8'd1);
		add_random_items(25);
		settle();

		// group length past sixteen, upper data bits of the register ignored
		set_config(8'hE3, 8'd20, 8'($urandom_range(0, 255)));
		add_random_items(25);
		settle();

		// last part: random setting, no idling on either side
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		set_config(8'($urandom_range(1, 16)), 8'($urandom_range(1, 16)),
		           8'($urandom_range(0, 255)));
		add_random_items(30);
		settle();

		if (word_errors == 0 && readback_words.size() == 0)
			$display("** pwm_encoder_capture_history: PASSED **");
		else
			$display("** pwm_encoder_capture_history: FAILED **");
		$finish;
	end

endmodule
